@@ design/ped_pkg.sv @@
package ped_pkg;

  localparam int MAX_TERMS = 16;
  localparam int COEF_BITS = 8;
  localparam int IDX_W     = $clog2(MAX_TERMS);
  localparam int LCNT_W    = $clog2(MAX_TERMS + 1);

  typedef logic [COEF_BITS-1:0] coef_t;
  typedef logic [IDX_W-1:0]     idx_t;

  // datapath operations issued by the controller
  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_INIT,
    OP_RED_GO,
    OP_RED_WR,
    OP_SCAN_INIT,
    OP_SCAN_B,
    OP_INV_INIT,
    OP_INV_GO,
    OP_INV_WR,
    OP_SCAN_T,
    OP_T_GO,
    OP_T_WR,
    OP_SUB_GO,
    OP_SUB_WR,
    OP_T_END,
    OP_COF_INIT,
    OP_COF_GO,
    OP_COF_WR,
    OP_COF_NEXT,
    OP_SWAP,
    OP_SCAN_O,
    OP_OUT_LD
  } dp_op_e;

  typedef struct packed {
    dp_op_e op;
  } dp_cmd_t;

  typedef struct packed {
    logic load_full;
    logic i_last;
    logic mul_busy;
    logic rb_nz;
    logic k_zero;
    logic e_zero;
    logic tm_nz;
    logic k_lt_db;
    logic db_zero;
    logic i_eq_dbm1;
    logic q_nz;
    logic o_nz;
    logic out_last;
  } dp_sts_t;

  // (a - b) mod p for a, b below p
  function automatic coef_t sub_mod(coef_t a, coef_t b, coef_t p);
    logic [COEF_BITS:0] s;
    s = {1'b0, a} - {1'b0, b};
    if (a < b) s = s + {1'b0, p};
    return s[COEF_BITS-1:0];
  endfunction

endpackage

@@ design/ped_in_if.sv @@
interface ped_in_if import ped_pkg::*;;
  logic  valid;
  logic  ready;
  coef_t coef_a;
  coef_t coef_b;
  logic  last_coef;

  modport source (output valid, output coef_a, output coef_b, output last_coef, input ready);
  modport sink   (input valid, input coef_a, input coef_b, input last_coef, output ready);
endinterface

@@ design/ped_out_if.sv @@
interface ped_out_if import ped_pkg::*;;
  logic  valid;
  logic  ready;
  coef_t gcd_coef;
  coef_t cofactor_x_coef;
  coef_t cofactor_y_coef;
  logic  last_out;

  modport source (output valid, output gcd_coef, output cofactor_x_coef,
                  output cofactor_y_coef, output last_out, input ready);
  modport sink   (input valid, input gcd_coef, input cofactor_x_coef,
                  input cofactor_y_coef, input last_out, output ready);
endinterface

@@ design/ped_mulmod.sv @@
module ped_mulmod import ped_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  start_i,
  input  coef_t mcand_i,
  input  coef_t mplier_i,
  input  coef_t modulus_i,
  output logic  busy_o,
  output coef_t product_o
);

  localparam int STEP_W = $clog2(COEF_BITS + 1);

  logic              busy_q;
  logic [STEP_W-1:0] step_q;
  coef_t             acc_q, acc_d;
  coef_t             cand_q;
  coef_t             mpl_q;
  logic [COEF_BITS:0] dbl, dred, sum, sred;

  // one shift-add step, multiplier msb first
  always_comb begin
    dbl  = {acc_q, 1'b0};
    dred = (dbl >= {1'b0, modulus_i}) ? dbl - {1'b0, modulus_i} : dbl;
    sum  = {1'b0, dred[COEF_BITS-1:0]} + {1'b0, cand_q};
    sred = (sum >= {1'b0, modulus_i}) ? sum - {1'b0, modulus_i} : sum;
    acc_d = mpl_q[COEF_BITS-1] ? sred[COEF_BITS-1:0] : dred[COEF_BITS-1:0];
  end

  // step control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      step_q <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      step_q <= STEP_W'(COEF_BITS);
    end else if (busy_q) begin
      step_q <= step_q - 1'b1;
      if (step_q == STEP_W'(1)) busy_q <= 1'b0;
    end
  end

  // operands and accumulator
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      acc_q  <= '0;
      cand_q <= mcand_i;
      mpl_q  <= mplier_i;
    end else if (busy_q) begin
      acc_q <= acc_d;
      mpl_q <= {mpl_q[COEF_BITS-2:0], 1'b0};
    end
  end

  assign busy_o    = busy_q;
  assign product_o = acc_q;

endmodule

@@ design/ped_ctrl.sv @@
module ped_ctrl import ped_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  input  logic    in_last_i,
  output logic    in_ready_o,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  input  dp_sts_t sts_i,
  output dp_cmd_t cmd_o
);

  localparam logic [4:0] S_LOAD     = 5'd0;
  localparam logic [4:0] S_START    = 5'd1;
  localparam logic [4:0] S_RED_GO   = 5'd2;
  localparam logic [4:0] S_RED_W    = 5'd3;
  localparam logic [4:0] S_DB_INIT  = 5'd4;
  localparam logic [4:0] S_DB_SCAN  = 5'd5;
  localparam logic [4:0] S_INV_INIT = 5'd6;
  localparam logic [4:0] S_INV_CHK  = 5'd7;
  localparam logic [4:0] S_INV_W    = 5'd8;
  localparam logic [4:0] S_DR_INIT  = 5'd9;
  localparam logic [4:0] S_DR_SCAN  = 5'd10;
  localparam logic [4:0] S_T_GO     = 5'd11;
  localparam logic [4:0] S_T_W      = 5'd12;
  localparam logic [4:0] S_SUB_GO   = 5'd13;
  localparam logic [4:0] S_SUB_W    = 5'd14;
  localparam logic [4:0] S_T_END    = 5'd15;
  localparam logic [4:0] S_COF_INIT = 5'd16;
  localparam logic [4:0] S_COF_CHK  = 5'd17;
  localparam logic [4:0] S_COF_W    = 5'd18;
  localparam logic [4:0] S_SWAP     = 5'd19;
  localparam logic [4:0] S_OUT_INIT = 5'd20;
  localparam logic [4:0] S_OUT_SCAN = 5'd21;
  localparam logic [4:0] S_OUT_LD   = 5'd22;
  localparam logic [4:0] S_OUT_W    = 5'd23;

  logic [4:0] state_q, state_d;

  // sequencing of loading, reduction, the division rounds and result output
  always_comb begin
    state_d    = state_q;
    cmd_o.op   = OP_NONE;
    in_ready_o = 1'b0;
    out_valid_o = 1'b0;
    case (state_q)
      S_LOAD: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.op = OP_LOAD;
          if (in_last_i || sts_i.load_full) state_d = S_START;
        end
      end
      S_START: begin
        cmd_o.op = OP_INIT;
        state_d  = S_RED_GO;
      end
      S_RED_GO: begin
        cmd_o.op = OP_RED_GO;
        state_d  = S_RED_W;
      end
      S_RED_W: begin
        if (!sts_i.mul_busy) begin
          cmd_o.op = OP_RED_WR;
          state_d  = sts_i.i_last ? S_DB_INIT : S_RED_GO;
        end
      end
      S_DB_INIT: begin
        cmd_o.op = OP_SCAN_INIT;
        state_d  = S_DB_SCAN;
      end
      S_DB_SCAN: begin
        cmd_o.op = OP_SCAN_B;
        if (sts_i.rb_nz) state_d = S_INV_INIT;
        else if (sts_i.k_zero) state_d = S_OUT_INIT;
      end
      S_INV_INIT: begin
        cmd_o.op = OP_INV_INIT;
        state_d  = S_INV_CHK;
      end
      S_INV_CHK: begin
        if (sts_i.e_zero) begin
          state_d = S_DR_INIT;
        end else begin
          cmd_o.op = OP_INV_GO;
          state_d  = S_INV_W;
        end
      end
      S_INV_W: begin
        if (!sts_i.mul_busy) begin
          cmd_o.op = OP_INV_WR;
          state_d  = S_INV_CHK;
        end
      end
      S_DR_INIT: begin
        cmd_o.op = OP_SCAN_INIT;
        state_d  = S_DR_SCAN;
      end
      S_DR_SCAN: begin
        cmd_o.op = OP_SCAN_T;
        if (sts_i.k_lt_db) state_d = S_COF_INIT;
        else if (sts_i.tm_nz) state_d = S_T_GO;
        else if (sts_i.k_zero) state_d = S_COF_INIT;
      end
      S_T_GO: begin
        cmd_o.op = OP_T_GO;
        state_d  = S_T_W;
      end
      S_T_W: begin
        if (!sts_i.mul_busy) begin
          cmd_o.op = OP_T_WR;
          state_d  = sts_i.db_zero ? S_T_END : S_SUB_GO;
        end
      end
      S_SUB_GO: begin
        cmd_o.op = OP_SUB_GO;
        state_d  = S_SUB_W;
      end
      S_SUB_W: begin
        if (!sts_i.mul_busy) begin
          cmd_o.op = OP_SUB_WR;
          state_d  = sts_i.i_eq_dbm1 ? S_T_END : S_SUB_GO;
        end
      end
      S_T_END: begin
        cmd_o.op = OP_T_END;
        state_d  = S_DR_SCAN;
      end
      S_COF_INIT: begin
        cmd_o.op = OP_COF_INIT;
        state_d  = S_COF_CHK;
      end
      S_COF_CHK: begin
        if (sts_i.q_nz) begin
          cmd_o.op = OP_COF_GO;
          state_d  = S_COF_W;
        end else begin
          cmd_o.op = OP_COF_NEXT;
          if (sts_i.i_last) state_d = S_SWAP;
        end
      end
      S_COF_W: begin
        if (!sts_i.mul_busy) begin
          cmd_o.op = OP_COF_WR;
          state_d  = sts_i.i_last ? S_SWAP : S_COF_CHK;
        end
      end
      S_SWAP: begin
        cmd_o.op = OP_SWAP;
        state_d  = S_DB_INIT;
      end
      S_OUT_INIT: begin
        cmd_o.op = OP_SCAN_INIT;
        state_d  = S_OUT_SCAN;
      end
      S_OUT_SCAN: begin
        cmd_o.op = OP_SCAN_O;
        if (sts_i.o_nz || sts_i.k_zero) state_d = S_OUT_LD;
      end
      S_OUT_LD: begin
        cmd_o.op = OP_OUT_LD;
        state_d  = S_OUT_W;
      end
      S_OUT_W: begin
        out_valid_o = 1'b1;
        if (out_ready_i) state_d = sts_i.out_last ? S_LOAD : S_OUT_LD;
      end
      default: state_d = S_LOAD;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= S_LOAD;
    else         state_q <= state_d;
  end

  // input and output sides never open together
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o))
    else $error("input and output open together");

  // the final item of an answer returns to loading
  a_last_to_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i && sts_i.out_last) |=> in_ready_o)
    else $error("not loading after final item");

  // a result write only follows a finished multiply
  a_wr_after_mul: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.op == OP_RED_WR || cmd_o.op == OP_INV_WR || cmd_o.op == OP_T_WR ||
     cmd_o.op == OP_SUB_WR || cmd_o.op == OP_COF_WR) |-> !sts_i.mul_busy)
    else $error("write while multiplier busy");

endmodule

@@ design/ped_dp.sv @@
module ped_dp import ped_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  dp_cmd_t cmd_i,
  output dp_sts_t sts_o,
  input  logic    cfg_we_i,
  input  coef_t   cfg_wdata_i,
  input  coef_t   coef_a_i,
  input  coef_t   coef_b_i,
  output coef_t   gcd_o,
  output coef_t   x_o,
  output coef_t   y_o,
  output logic    last_o
);

  coef_t ra_q [MAX_TERMS];
  coef_t rb_q [MAX_TERMS];
  coef_t tm_q [MAX_TERMS];
  coef_t q_q  [MAX_TERMS];
  coef_t xp_q [MAX_TERMS];
  coef_t xc_q [MAX_TERMS];
  coef_t yp_q [MAX_TERMS];
  coef_t yc_q [MAX_TERMS];

  coef_t             p_q;
  logic [LCNT_W-1:0] cnt_q;
  idx_t              i_q, j_q, k_q, db_q, dr_q, top_q;
  coef_t             r_q, bb_q, e_q, t_q;
  coef_t             gcd_q, x_q, y_q;
  logic              last_q;

  idx_t  ra_idx, rb_idx, tm_idx, xp_idx, sidx, pidx;
  coef_t ra_rd, rb_rd, tm_rd, q_rd, xp_rd, xc_rd, yp_rd, yc_rd;
  logic [IDX_W:0] ij_sum;
  logic  mul_start;
  coef_t a_cand, a_mpl, b_cand, b_mpl, a_prod, b_prod;
  logic  a_busy, b_busy;

  // read ports, one address per store
  always_comb begin
    sidx   = i_q + dr_q - db_q;
    pidx   = i_q + j_q;
    ij_sum = {1'b0, i_q} + {1'b0, j_q};
    ra_idx = (cmd_i.op == OP_SCAN_O) ? k_q : i_q;
    case (cmd_i.op)
      OP_SCAN_B:   rb_idx = k_q;
      OP_INV_INIT: rb_idx = db_q;
      default:     rb_idx = i_q;
    endcase
    case (cmd_i.op)
      OP_SCAN_T: tm_idx = k_q;
      OP_SUB_WR: tm_idx = sidx;
      default:   tm_idx = dr_q;
    endcase
    case (cmd_i.op)
      OP_SCAN_O: xp_idx = k_q;
      OP_COF_WR: xp_idx = pidx;
      default:   xp_idx = i_q;
    endcase
    ra_rd = ra_q[ra_idx];
    rb_rd = rb_q[rb_idx];
    tm_rd = tm_q[tm_idx];
    q_rd  = q_q[j_q];
    xp_rd = xp_q[xp_idx];
    yp_rd = yp_q[xp_idx];
    xc_rd = xc_q[i_q];
    yc_rd = yc_q[i_q];
  end

  // multiplier operands
  always_comb begin
    mul_start = 1'b0;
    a_cand = COEF_BITS'(1);
    a_mpl  = ra_rd;
    b_cand = COEF_BITS'(1);
    b_mpl  = rb_rd;
    case (cmd_i.op)
      OP_RED_GO: mul_start = 1'b1;
      OP_INV_GO: begin
        mul_start = 1'b1;
        a_cand = r_q;  a_mpl = bb_q;
        b_cand = bb_q; b_mpl = bb_q;
      end
      OP_T_GO: begin
        mul_start = 1'b1;
        a_cand = r_q; a_mpl = tm_rd;
      end
      OP_SUB_GO: begin
        mul_start = 1'b1;
        a_cand = t_q; a_mpl = rb_rd;
      end
      OP_COF_GO: begin
        mul_start = 1'b1;
        a_cand = xc_rd; a_mpl = q_rd;
        b_cand = yc_rd; b_mpl = q_rd;
      end
      default: mul_start = 1'b0;
    endcase
  end

  ped_mulmod u_mul_a (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (mul_start),
    .mcand_i   (a_cand),
    .mplier_i  (a_mpl),
    .modulus_i (p_q),
    .busy_o    (a_busy),
    .product_o (a_prod)
  );

  ped_mulmod u_mul_b (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (mul_start),
    .mcand_i   (b_cand),
    .mplier_i  (b_mpl),
    .modulus_i (p_q),
    .busy_o    (b_busy),
    .product_o (b_prod)
  );

  // status to the controller
  always_comb begin
    sts_o.load_full = (cnt_q == LCNT_W'(MAX_TERMS - 1));
    sts_o.i_last    = (i_q == IDX_W'(MAX_TERMS - 1));
    sts_o.mul_busy  = a_busy | b_busy;
    sts_o.rb_nz     = (rb_rd != '0);
    sts_o.k_zero    = (k_q == '0);
    sts_o.e_zero    = (e_q == '0);
    sts_o.tm_nz     = (tm_rd != '0);
    sts_o.k_lt_db   = (k_q < db_q);
    sts_o.db_zero   = (db_q == '0);
    sts_o.i_eq_dbm1 = (i_q == db_q - 1'b1);
    sts_o.q_nz      = (q_rd != '0);
    sts_o.o_nz      = (ra_rd != '0) || (xp_rd != '0) || (yp_rd != '0);
    sts_o.out_last  = last_q;
  end

  // modulus register, values below two act as two
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_q <= COEF_BITS'(2);
    end else if (cfg_we_i) begin
      p_q <= (cfg_wdata_i < COEF_BITS'(2)) ? COEF_BITS'(2) : cfg_wdata_i;
    end
  end

  // load counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (cmd_i.op == OP_LOAD) begin
      cnt_q <= cnt_q + 1'b1;
    end else if (cmd_i.op == OP_INIT) begin
      cnt_q <= '0;
    end
  end

  // stores, indexes and scalar work registers
  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      OP_LOAD: begin
        ra_q[cnt_q[IDX_W-1:0]] <= coef_a_i;
        rb_q[cnt_q[IDX_W-1:0]] <= coef_b_i;
      end
      OP_INIT: begin
        for (int n = 0; n < MAX_TERMS; n++) begin
          if (LCNT_W'(n) >= cnt_q) begin
            ra_q[n] <= '0;
            rb_q[n] <= '0;
          end
          xp_q[n] <= (n == 0) ? COEF_BITS'(1) : '0;
          xc_q[n] <= '0;
          yp_q[n] <= '0;
          yc_q[n] <= (n == 0) ? COEF_BITS'(1) : '0;
        end
        i_q <= '0;
      end
      OP_RED_WR: begin
        ra_q[i_q] <= a_prod;
        rb_q[i_q] <= b_prod;
        i_q <= i_q + 1'b1;
      end
      OP_SCAN_INIT: begin
        k_q <= IDX_W'(MAX_TERMS - 1);
        i_q <= '0;
      end
      OP_SCAN_B: begin
        if (rb_rd != '0) db_q <= k_q;
        else             k_q  <= k_q - 1'b1;
      end
      OP_INV_INIT: begin
        for (int n = 0; n < MAX_TERMS; n++) begin
          tm_q[n] <= ra_q[n];
          q_q[n]  <= '0;
        end
        r_q  <= COEF_BITS'(1);
        bb_q <= rb_rd;
        e_q  <= p_q - COEF_BITS'(2);
      end
      OP_INV_WR: begin
        if (e_q[0]) r_q <= a_prod;
        bb_q <= b_prod;
        e_q  <= e_q >> 1;
      end
      OP_SCAN_T: begin
        if (tm_rd != '0) dr_q <= k_q;
        else             k_q  <= k_q - 1'b1;
      end
      OP_T_WR: begin
        t_q <= a_prod;
        q_q[dr_q - db_q] <= a_prod;
        i_q <= '0;
      end
      OP_SUB_WR: begin
        tm_q[sidx] <= sub_mod(tm_rd, a_prod, p_q);
        i_q <= i_q + 1'b1;
      end
      OP_T_END: begin
        tm_q[dr_q] <= '0;
        k_q <= dr_q;
      end
      OP_COF_INIT: begin
        i_q <= '0;
        j_q <= '0;
      end
      OP_COF_GO: begin
        i_q <= i_q;
      end
      OP_COF_NEXT, OP_COF_WR: begin
        if (cmd_i.op == OP_COF_WR) begin
          xp_q[pidx] <= sub_mod(xp_rd, a_prod, p_q);
          yp_q[pidx] <= sub_mod(yp_rd, b_prod, p_q);
        end
        if (ij_sum == (IDX_W + 1)'(MAX_TERMS - 1)) begin
          i_q <= i_q + 1'b1;
          j_q <= '0;
        end else begin
          j_q <= j_q + 1'b1;
        end
      end
      OP_SWAP: begin
        for (int n = 0; n < MAX_TERMS; n++) begin
          xp_q[n] <= xc_q[n];
          xc_q[n] <= xp_q[n];
          yp_q[n] <= yc_q[n];
          yc_q[n] <= yp_q[n];
          ra_q[n] <= rb_q[n];
          rb_q[n] <= tm_q[n];
        end
      end
      OP_SCAN_O: begin
        if ((ra_rd != '0) || (xp_rd != '0) || (yp_rd != '0) || (k_q == '0)) top_q <= k_q;
        else k_q <= k_q - 1'b1;
      end
      OP_OUT_LD: begin
        gcd_q  <= ra_rd;
        x_q    <= xp_rd;
        y_q    <= yp_rd;
        last_q <= (i_q == top_q);
        i_q    <= i_q + 1'b1;
      end
      default: begin
        i_q <= i_q;
      end
    endcase
  end

  assign gcd_o  = gcd_q;
  assign x_o    = x_q;
  assign y_o    = y_q;
  assign last_o = last_q;

endmodule

@@ design/poly_extended_euclid_gfp.sv @@
// loading takes one item per cycle; the item with the last flag (or the sixteenth) starts a run
// every modular multiply runs on a shift-add unit between an issue and a write state; a run opens
// with 16 reducing multiplies, then each division round scans the divisor and remainder terms,
// makes 136 cofactor term checks and multiplies for the inverse, remainder and cofactor updates
// results leave one at a time, each held until taken; input is held off until the last one
// reset clears the controller and load count and sets the modulus to 2
module poly_extended_euclid_gfp import ped_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  cfg_we_i,
  input  coef_t cfg_wdata_i,
  ped_in_if.sink    in_i,
  ped_out_if.source out_o
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  ped_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_last_i   (in_i.last_coef),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  ped_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .coef_a_i    (in_i.coef_a),
    .coef_b_i    (in_i.coef_b),
    .gcd_o       (out_o.gcd_coef),
    .x_o         (out_o.cofactor_x_coef),
    .y_o         (out_o.cofactor_y_coef),
    .last_o      (out_o.last_out)
  );

endmodule

@@ tb/sv/poly_extended_euclid_gfp_check.sv @@
module poly_extended_euclid_gfp_check import ped_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      cfg_we_i,
  input  coef_t     cfg_wdata_i,
  ped_in_if.sink    in_mon,
  ped_out_if.sink   out_mon,
  output int        fail_count_o,
  output int        pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    coef_t g;
    coef_t x;
    coef_t y;
    logic  last;
  } triple_t;

  typedef int poly_t [MAX_TERMS];

  triple_t triple_q[$];
  coef_t   modulus;
  coef_t   load_a [MAX_TERMS];
  coef_t   load_b [MAX_TERMS];
  int      load_n;
  poly_t   quo;

  assign pending_o = triple_q.size();

  function automatic int deg_of(poly_t v);
    for (int i = MAX_TERMS - 1; i >= 0; i--) if (v[i] != 0) return i;
    return -1;
  endfunction

  // c^(p-2) mod p
  function automatic int inv_mod(int c, int p);
    int r, b, e;
    r = 1 % p; b = c % p; e = p - 2;
    while (e != 0) begin
      if (e & 1) r = (r * b) % p;
      b = (b * b) % p;
      e = e >> 1;
    end
    return r;
  endfunction

  // remainder in place, quotient into quo
  task automatic divide_poly(ref poly_t rem, input poly_t dv, input int p);
    int db, dr, inv, t;
    for (int i = 0; i < MAX_TERMS; i++) quo[i] = 0;
    db = deg_of(dv);
    if (db < 0) return;
    inv = inv_mod(dv[db], p);
    dr = deg_of(rem);
    while (dr >= db) begin
      t = (rem[dr] * inv) % p;
      quo[dr-db] = (quo[dr-db] + t) % p;
      for (int i = 0; i < db; i++)
        rem[i+dr-db] = (rem[i+dr-db] + p - (t * dv[i]) % p) % p;
      rem[dr] = 0;
      dr = deg_of(rem);
    end
  endtask

  // prev, cur := cur, prev - cur*quo
  task automatic update_cofactor(ref poly_t prv, ref poly_t cur, input int p);
    int    prod [MAX_TERMS];
    poly_t nxt;
    for (int i = 0; i < MAX_TERMS; i++) prod[i] = 0;
    for (int i = 0; i < MAX_TERMS; i++)
      if (cur[i] != 0)
        for (int j = 0; i + j < MAX_TERMS; j++)
          prod[i+j] = (prod[i+j] + cur[i] * quo[j]) % p;
    for (int i = 0; i < MAX_TERMS; i++) nxt[i] = (prv[i] + p - prod[i]) % p;
    prv = cur;
    cur = nxt;
  endtask

  task automatic predict_gcd();
    int    p, top, n;
    poly_t ra, rb, tmp, xp, xc, yp, yc;
    triple_t t;
    p = (modulus < 2) ? 2 : modulus;
    for (int i = 0; i < MAX_TERMS; i++) begin
      ra[i] = (i < load_n) ? load_a[i] % p : 0;
      rb[i] = (i < load_n) ? load_b[i] % p : 0;
      xp[i] = 0; xc[i] = 0; yp[i] = 0; yc[i] = 0;
    end
    xp[0] = 1;
    yc[0] = 1;
    while (deg_of(rb) >= 0) begin
      tmp = ra;
      divide_poly(tmp, rb, p);
      update_cofactor(xp, xc, p);
      update_cofactor(yp, yc, p);
      ra = rb;
      rb = tmp;
    end
    top = deg_of(ra);
    if (deg_of(xp) > top) top = deg_of(xp);
    if (deg_of(yp) > top) top = deg_of(yp);
    n = (top < 0) ? 1 : top + 1;
    for (int k = 0; k < n; k++) begin
      t.g = ra[k][7:0];
      t.x = xp[k][7:0];
      t.y = yp[k][7:0];
      t.last = (k == n - 1);
      triple_q.push_back(t);
    end
  endtask

  // watch config, input items and results
  always @(posedge clk_i or negedge rst_ni) begin
    triple_t exp_t;
    if (!rst_ni) begin
      modulus = 2;
      load_n = 0;
      fail_count_o = 0;
      triple_q.delete();
    end else begin
      if (cfg_we_i) modulus = cfg_wdata_i;
      if (out_mon.valid && out_mon.ready) begin
        if (triple_q.size() == 0) begin
          $display("%t: unexpected item g=%0d x=%0d y=%0d last=%0b", $time,
                   out_mon.gcd_coef, out_mon.cofactor_x_coef, out_mon.cofactor_y_coef,
                   out_mon.last_out);
          fail_count_o++;
        end else begin
          exp_t = triple_q.pop_front();
          if (exp_t.g !== out_mon.gcd_coef || exp_t.x !== out_mon.cofactor_x_coef ||
              exp_t.y !== out_mon.cofactor_y_coef || exp_t.last !== out_mon.last_out) begin
            $display("%t: expected g=%0d x=%0d y=%0d last=%0b, got g=%0d x=%0d y=%0d last=%0b",
                     $time, exp_t.g, exp_t.x, exp_t.y, exp_t.last, out_mon.gcd_coef,
                     out_mon.cofactor_x_coef, out_mon.cofactor_y_coef, out_mon.last_out);
            fail_count_o++;
          end
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        if (load_n >= MAX_TERMS) load_n = 0;
        load_a[load_n] = in_mon.coef_a;
        load_b[load_n] = in_mon.coef_b;
        load_n++;
        if (in_mon.last_coef || load_n >= MAX_TERMS) begin
          predict_gcd();
          load_n = 0;
        end
      end
    end
  end
endmodule

@@ tb/sv/poly_extended_euclid_gfp_test.sv @@
module poly_extended_euclid_gfp_test;
  import ped_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 6000000;
  localparam int PRIMES [8] = '{2, 3, 5, 7, 13, 31, 127, 251};

  logic  clk_i = 1'b0;
  logic  rst_ni = 1'b0;
  logic  cfg_we_i = 1'b0;
  coef_t cfg_wdata_i = '0;
  int    fail_count, pending, cycles;
  logic  hold_results = 1'b0;
  logic  hold_start = 1'b0;
  logic  stim_done = 1'b0;
  int    cur_p = 2;

  ped_in_if  in_ch ();
  ped_out_if out_ch ();

  poly_extended_euclid_gfp dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .cfg_we_i(cfg_we_i), .cfg_wdata_i(cfg_wdata_i),
    .in_i(in_ch.sink), .out_o(out_ch.source)
  );

  poly_extended_euclid_gfp_check checker_i (
    .clk_i(clk_i), .rst_ni(rst_ni), .cfg_we_i(cfg_we_i), .cfg_wdata_i(cfg_wdata_i),
    .in_mon(in_ch.sink), .out_mon(out_ch.sink),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // cycle limit
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // long receiver hold, counted in cycles here
  initial begin
    wait (hold_start);
    hold_results = 1'b1;
    repeat (3000) @(negedge clk_i);
    hold_results = 1'b0;
  end

  // result side: random stalls, long hold when asked
  initial begin
    int gap;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_results) begin
        out_ch.ready <= 1'b0;
      end else if (out_ch.ready && out_ch.valid) begin
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 3);
        if (gap > 0) begin
          out_ch.ready <= 1'b0;
          repeat (gap) @(negedge clk_i);
        end
        out_ch.ready <= 1'b1;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  task automatic send_pair(int a, int b, bit last, bit no_gap = 0);
    int gap;
    gap = no_gap ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_ch.valid     <= 1'b1;
    in_ch.coef_a    <= COEF_BITS'(a);
    in_ch.coef_b    <= COEF_BITS'(b);
    in_ch.last_coef <= last;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic send_poly(int len, int maxv, bit force_last = 1);
    for (int i = 0; i < len; i++)
      send_pair($urandom_range(0, maxv), $urandom_range(0, maxv),
                (i == len - 1) && force_last);
  endtask

  task automatic wait_idle_and_set(int p);
    in_ch.valid <= 1'b0;
    @(negedge clk_i);
    while (pending != 0) @(negedge clk_i);
    repeat (20000) @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= COEF_BITS'(p);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    cur_p = p;
  endtask

  initial begin
    int len;
    in_ch.valid = 1'b0;
    in_ch.coef_a = '0;
    in_ch.coef_b = '0;
    in_ch.last_coef = 1'b0;
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed: reset modulus 2, zero b, both zero, single terms
    send_pair(0, 0, 1);
    send_pair(1, 0, 0); send_pair(1, 0, 1);
    send_pair(1, 1, 0); send_pair(0, 1, 1);
    wait_idle_and_set(251);
    send_pair(250, 250, 0); send_pair(3, 7, 0); send_pair(250, 1, 1);
    send_pair(5, 0, 1);
    send_pair(0, 9, 1);
    // sixteen pairs with no last flag, every coefficient with its top bit set
    for (int i = 0; i < MAX_TERMS; i++) send_pair(255 - i, 128 + i, 0);
    wait_idle_and_set(0);
    send_pair(3, 1, 0); send_pair(1, 1, 1);
    wait_idle_and_set(9);
    send_poly(4, 255);
    wait_idle_and_set(7);
    send_poly(3, 255);

    // long receiver hold while input keeps coming
    hold_start = 1'b1;
    send_poly(3, 6);
    send_poly(4, 6);
    send_poly(2, 6);

    // random phases over several moduli
    for (int ph = 0; ph < 8; ph++) begin
      wait_idle_and_set(PRIMES[ph]);
      for (int k = 0; k < 6; k++) begin
        len = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 17) : $urandom_range(1, 5);
        send_poly(len > MAX_TERMS ? MAX_TERMS : len,
                  ($urandom_range(0, 9) == 0) ? 255 : cur_p - 1, len <= MAX_TERMS);
      end
    end

    in_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (200) @(negedge clk_i);
    if (fail_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end
endmodule
